// ===== rtl/keypad_debounce_make_break_defines.svh =====
// assertion macros for the keypad debounce block
// used by kdmb_emitter, the one module that carries concurrent checks; no other dependencies
`ifndef KEYPAD_DEBOUNCE_MAKE_BREAK_DEFINES_SVH
`define KEYPAD_DEBOUNCE_MAKE_BREAK_DEFINES_SVH
`ifndef NO_ASSERTIONS
// clocked check, suspended while reset is held
`define KDMB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define KDMB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define KDMB_ASSERT(lbl, prop, msg)
`define KDMB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/kdmb_pkg.sv =====
// shared constants, types and helpers for the keypad debounce block
// no dependencies
package kdmb_pkg;

    localparam int WORD_W      = 32;
    localparam int CODE_W      = 8;
    localparam int WORD_SLOTS  = 4;
    localparam int MAX_SLOTS   = 8;
    localparam int KEY_SLOTS   = 4;
    localparam int TIMER_W     = 17;
    localparam int CFG_W       = 16;
    localparam int SLOT_IDX_W  = 4;

    localparam logic [TIMER_W-1:0] SCAN_STEP_MS  = 17'd10;
    localparam logic [CFG_W-1:0]   SETTLE_RESET  = 16'd30;
    localparam logic [CODE_W-1:0]  CODE_EMPTY    = 8'h00;

    // events of one tick: make bits low, break bits above them
    typedef struct packed {
        logic [2*MAX_SLOTS-1:0] mask;
        logic [WORD_W-1:0]      held;
        logic [WORD_W-1:0]      rep;
    } t_events;

    // code in one slot; slots past the word read as empty
    function automatic logic [CODE_W-1:0] slot_code(
        input logic [WORD_W-1:0]     word,
        input logic [SLOT_IDX_W-1:0] idx
    );
        logic [CODE_W-1:0] code;
        code = CODE_EMPTY;
        if (idx < SLOT_IDX_W'(WORD_SLOTS)) begin
            code = word[idx[1:0]*CODE_W +: CODE_W];
        end
        return code;
    endfunction

endpackage

// ===== rtl/kdmb_tracker.sv =====
// debounce state (held word, settle timer, reported word) and the event mask
// depends on kdmb_pkg
module kdmb_tracker #(
    parameter int KEY_SLOTS = kdmb_pkg::KEY_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [kdmb_pkg::WORD_W-1:0]     i_word,
    input  logic [kdmb_pkg::CFG_W-1:0]      i_settle,
    output kdmb_pkg::t_events               o_ev
);

    logic [kdmb_pkg::WORD_W-1:0]  r_held, n_held;
    logic [kdmb_pkg::WORD_W-1:0]  r_rep, n_rep;
    logic [kdmb_pkg::TIMER_W-1:0] r_timer, n_timer;
    logic [kdmb_pkg::TIMER_W-1:0] settle_ext;
    logic                         report;

    assign settle_ext = kdmb_pkg::TIMER_W'(i_settle);

    // held word and settle timer for this tick
    always_comb begin
        n_held  = r_held;
        n_timer = r_timer;
        if (i_word != r_held) begin
            n_held  = i_word;
            n_timer = '0;
        end else if (r_timer < settle_ext) begin
            n_timer = r_timer + kdmb_pkg::SCAN_STEP_MS;
        end
    end

    assign report = (n_held != r_rep) && (n_timer >= settle_ext);

    // make and break flags per slot
    always_comb begin
        logic [kdmb_pkg::CODE_W-1:0] hc, rc;
        logic                        h_in_r, r_in_h;
        o_ev      = '0;
        o_ev.held = n_held;
        o_ev.rep  = r_rep;
        for (int s = 0; s < KEY_SLOTS; s++) begin
            hc     = kdmb_pkg::slot_code(n_held, kdmb_pkg::SLOT_IDX_W'(s));
            rc     = kdmb_pkg::slot_code(r_rep, kdmb_pkg::SLOT_IDX_W'(s));
            h_in_r = 1'b0;
            r_in_h = 1'b0;
            for (int t = 0; t < KEY_SLOTS; t++) begin
                if (kdmb_pkg::slot_code(r_rep, kdmb_pkg::SLOT_IDX_W'(t)) == hc) begin
                    h_in_r = 1'b1;
                end
                if (kdmb_pkg::slot_code(n_held, kdmb_pkg::SLOT_IDX_W'(t)) == rc) begin
                    r_in_h = 1'b1;
                end
            end
            o_ev.mask[s]           = report && (hc != kdmb_pkg::CODE_EMPTY) && !h_in_r;
            o_ev.mask[KEY_SLOTS+s] = report && (rc != kdmb_pkg::CODE_EMPTY) && !r_in_h;
        end
    end

    assign n_rep = report ? n_held : r_rep;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_rep   <= '0;
            r_timer <= '0;
        end else if (i_fire) begin
            r_held  <= n_held;
            r_rep   <= n_rep;
            r_timer <= n_timer;
        end
    end

endmodule

// ===== rtl/kdmb_emitter.sv =====
// event buffer: sends the flagged make and break events one word per cycle while the receiver is ready
// depends on kdmb_pkg and keypad_debounce_make_break_defines.svh
`include "keypad_debounce_make_break_defines.svh"
module kdmb_emitter #(
    parameter int KEY_SLOTS = kdmb_pkg::KEY_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  kdmb_pkg::t_events             i_ev,
    output logic                          o_free,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [kdmb_pkg::CODE_W-1:0]   o_m_tdata,  // key_code
    output logic                          o_m_tuser,  // is_break
    output logic                          o_m_tlast   // last_event
);

    localparam int EV_N = 2 * KEY_SLOTS;

    logic [EV_N-1:0]             r_mask, n_mask;
    logic [kdmb_pkg::WORD_W-1:0] r_held;
    logic [kdmb_pkg::WORD_W-1:0] r_rep;
    logic [EV_N-1:0]             rest;
    logic                        take;

    assign rest       = r_mask & (r_mask - EV_N'(1));
    assign o_m_tvalid = |r_mask;
    assign o_m_tlast  = o_m_tvalid && (rest == '0);
    assign take       = o_m_tvalid && i_m_tready;
    assign o_free     = !o_m_tvalid || (take && o_m_tlast);

    // pick the lowest pending event
    always_comb begin
        o_m_tdata = kdmb_pkg::CODE_EMPTY;
        o_m_tuser = 1'b0;
        for (int j = EV_N - 1; j >= 0; j--) begin
            if (r_mask[j]) begin
                if (j < KEY_SLOTS) begin
                    o_m_tdata = kdmb_pkg::slot_code(r_held, kdmb_pkg::SLOT_IDX_W'(j));
                    o_m_tuser = 1'b0;
                end else begin
                    o_m_tdata = kdmb_pkg::slot_code(r_rep,
                                    kdmb_pkg::SLOT_IDX_W'(j - KEY_SLOTS));
                    o_m_tuser = 1'b1;
                end
            end
        end
    end

    // pending mask: load a new tick or retire the word just taken
    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_ev.mask[EV_N-1:0];
        end else if (take) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    // codes of the tick being sent
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_held <= i_ev.held;
            r_rep  <= i_ev.rep;
        end
    end

    `KDMB_ASSERT(a_load_only_when_free, (i_load && o_m_tvalid) |-> (take && o_m_tlast), "event buffer overwritten while words pending")
    `KDMB_ASSERT(a_more_after_nonlast, (take && !o_m_tlast) |=> o_m_tvalid, "events lost after a non-final word")
    `KDMB_ASSERT(a_idle_after_last, (take && o_m_tlast && !i_load) |=> !o_m_tvalid, "extra event after the final word")
    `KDMB_ASSERT(a_code_nonzero, o_m_tvalid |-> (o_m_tdata != kdmb_pkg::CODE_EMPTY), "empty slot sent as an event")

endmodule

// ===== rtl/keypad_debounce_make_break.sv =====
// Keypad debouncer with make/break events. Each input word is one 10 ms scan
// tick of four 8-bit key codes (0 = empty). A tick is taken into an input
// register and evaluated in one pass once the event buffer is free: held word,
// settle timer and reported word update, and the make/break events of the tick
// are loaded into an event buffer. The buffer sends one event word per cycle
// while the receiver is ready, lowest slot first, makes before breaks, tlast on
// the final one. A tick causes at most 2*KEY_SLOTS events (8 at the default);
// ticks are taken one per cycle when they cause at most one event and the
// receiver is ready, and otherwise wait until the buffer has sent its events.
// The input register accepts the next tick while events still drain.
// depends on kdmb_pkg, kdmb_tracker, kdmb_emitter
module keypad_debounce_make_break #(
    parameter int KEY_SLOTS = kdmb_pkg::KEY_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [kdmb_pkg::WORD_W-1:0]   i_s_tdata,   // scan_word
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [kdmb_pkg::CODE_W-1:0]   o_m_tdata,   // key_code
    output logic                          o_m_tuser,   // is_break
    output logic                          o_m_tlast,   // last_event
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kdmb_pkg::CFG_W-1:0]    i_cfg_data   // settle_time_ms
);

    logic                        r_in_valid;
    logic [kdmb_pkg::WORD_W-1:0] r_in_word;
    logic [kdmb_pkg::CFG_W-1:0]  r_settle;
    logic                        free;
    logic                        fire;
    kdmb_pkg::t_events           ev;

    // nothing is taken while reset is held
    assign fire        = r_in_valid && free;
    assign o_s_tready  = i_rst_n && (!r_in_valid || fire);
    assign o_cfg_ready = i_rst_n;

    // settle time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= kdmb_pkg::SETTLE_RESET;
        end else if (i_cfg_valid) begin
            r_settle <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_word <= i_s_tdata;
        end
    end

    kdmb_tracker #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (r_in_word),
        .i_settle (r_settle),
        .o_ev     (ev)
    );

    kdmb_emitter #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_ev       (ev),
        .o_free     (free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
